/* src/ocn_pkg.sv */
// Package for the organized cloud normal estimator.
// Holds the point type, the sequencer states, and the register and width constants.
`timescale 1ns / 1ps
`default_nettype none
package ocn_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COORD_W    = 24;
    localparam int ROW_W      = 12;
    localparam int RLEN_W     = 11;
    localparam int MINV_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VERT   = 2'd1;

    localparam logic [RLEN_W-1:0] ROW_LENGTH_RST = 11'd640;
    localparam logic [MINV_W-1:0] MIN_VERT_RST   = 15'd26214;
    localparam logic [ROW_W-1:0]  ROW_MAX        = 12'd4095;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WIN,
        ST_DIFF,
        ST_CROSS,
        ST_ABS,
        ST_SHIFT,
        ST_SQUARE,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

/* src/ocn_intf.sv */
// Stream interfaces for points, normals and configuration writes.
// Depends on ocn_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ocn_point_if import ocn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      frame_start;
    modport source (output valid, point_x, point_y, point_z, frame_start, input ready);
    modport sink (input valid, point_x, point_y, point_z, frame_start, output ready);
endinterface

interface ocn_normal_if import ocn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      normal_x;
    logic signed [15:0]      normal_y;
    logic [14:0]             normal_z;
    logic                    accepted;
    logic [ROW_W-1:0]        center_row;
    logic [9:0]              center_column;
    modport source (output valid, normal_x, normal_y, normal_z, accepted, center_row,
                    center_column, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, accepted, center_row,
                  center_column, output ready);
endinterface

interface ocn_cfg_if import ocn_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/ocn_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ocn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* src/organized_cloud_horizontal_normals.sv */
// Top level of the organized cloud normal estimator: line store, window and sequencer.
// Depends on ocn_pkg, the interfaces in ocn_intf and ocn_ram.
//
// Channel   Dir  Beat contents
// i_pt      in   point_x, point_y, point_z, frame_start
// o_nrm     out  normal_x, normal_y, normal_z, accepted, center_row, center_column
// i_cfg     in   index, data
//
// A border point only updates the line store and window. An interior point also takes one
// normalizing shift per excess bit, the 31-step bit-serial square root and three restoring
// divisions on one datapath; a zero neighbor ends it after the differences, a zero magnitude
// after the root. The shared 32x32 multiplier forms the cross product and the squares.
// Reset is synchronous; line store contents are undefined after reset and need no clearing.
// A finished beat waits in the output register while the next point is taken; the sequencer
// stalls in its last state only while that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module organized_cloud_horizontal_normals import ocn_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    ocn_point_if.sink    i_pt,
    ocn_normal_if.source o_nrm,
    ocn_cfg_if.sink      i_cfg
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(2 * MAX_WIDTH);
    localparam int LW = (CW + 2 > RLEN_W + 1) ? CW + 2 : RLEN_W + 1;

    t_state r_state, n_state;

    logic [RLEN_W-1:0] r_row_len;
    logic [MINV_W-1:0] r_min_vert;
    logic [ROW_W-1:0]  r_row_cnt;
    logic [CW-1:0]     r_col_cnt;
    logic [ROW_W-1:0]  r_row;
    logic [CW-1:0]     r_col;
    logic [AW-1:0]     r_addr_a;
    logic [AW-1:0]     r_addr_b;
    t_point            r_cur;
    t_point            r_tmp_a;
    t_point            r_win [3][3];

    logic signed [24:0] r_u [3];
    logic signed [24:0] r_v [3];
    logic               r_pts_ok;
    logic [4:0]         r_cnt;
    logic signed [49:0] r_n [3];
    logic [48:0]        r_mg [3];
    logic [1:0]         r_neg;
    logic signed [63:0] r_prod;
    logic [61:0]        r_sum;
    logic [61:0]        r_res;
    logic [61:0]        r_bit;
    logic               r_mag_ok;
    logic [1:0]         r_div_i;
    logic [31:0]        r_rem;
    logic [15:0]        r_numlo;
    logic [15:0]        r_q;
    logic [14:0]        r_qs [3];

    logic               r_ovalid;
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic [14:0]        r_nz;
    logic               r_acc;
    logic [ROW_W-1:0]   r_crow;
    logic [9:0]         r_ccol;

    logic               in_fire;
    logic               out_load;
    logic [ROW_W-1:0]   row_e;
    logic [CW-1:0]      col_raw;
    logic [CW-1:0]      col_e;
    logic [LW-1:0]      len_e;
    logic               row_last;
    logic [AW-1:0]      addr_lo;
    logic [AW-1:0]      addr_hi;
    logic [AW-1:0]      ram_raddr;
    logic               ram_we;
    logic [71:0]        ram_rdata;
    t_point             rd_point;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] mul;
    logic [48:0]        mg_or;
    logic [61:0]        root_t;
    logic               root_ge;
    logic [61:0]        root_res;
    logic               border_ok;
    logic               pts_nz;
    logic [30:0]        mag;
    logic [45:0]        num;
    logic [32:0]        rem2;
    logic               qbit;
    logic [15:0]        q_next;
    logic [4:0]         cnt_m1;
    logic               res_ok;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len  <= ROW_LENGTH_RST;
            r_min_vert <= MIN_VERT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_ROW_LENGTH: r_row_len  <= i_cfg.data[RLEN_W-1:0];
                REG_MIN_VERT:   r_min_vert <= i_cfg.data[MINV_W-1:0];
                default: ;
            endcase
        end
    end

    // Position of the arriving point.
    always_comb begin
        row_e   = i_pt.frame_start ? '0 : r_row_cnt;
        col_raw = i_pt.frame_start ? '0 : r_col_cnt;
        col_e   = ({1'b0, col_raw} < (CW + 1)'(MAX_WIDTH)) ? col_raw : '0;
        if (r_row_len < RLEN_W'(3)) begin
            len_e = LW'(3);
        end else if (LW'(r_row_len) > LW'(MAX_WIDTH)) begin
            len_e = LW'(MAX_WIDTH);
        end else begin
            len_e = LW'(r_row_len);
        end
        row_last = (LW'(col_e) + LW'(1)) >= len_e;
        addr_lo  = AW'(col_e);
        addr_hi  = AW'(MAX_WIDTH) + AW'(col_e);
    end

    assign in_fire     = i_pt.valid && i_pt.ready;
    assign out_load    = (r_state == ST_OUT) && (!r_ovalid || o_nrm.ready);
    assign rd_point    = t_point'(ram_rdata);
    assign border_ok   = (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
    assign mg_or       = r_mg[0] | r_mg[1] | r_mg[2];
    assign mag         = r_res[30:0];
    assign cnt_m1      = r_cnt - 5'd1;

    always_comb begin
        pts_nz = (r_win[1][1] != '0) && (r_win[2][2] != '0) && (r_win[2][0] != '0) &&
                 (r_win[0][0] != '0) && (r_win[0][2] != '0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_fire) n_state = ST_RD_A;
            ST_RD_A:   n_state = ST_RD_B;
            ST_RD_B:   n_state = ST_WIN;
            ST_WIN:    n_state = border_ok ? ST_DIFF : ST_IDLE;
            ST_DIFF:   n_state = pts_nz ? ST_CROSS : ST_OUT;
            ST_CROSS:  if (r_cnt == 5'd6) n_state = ST_ABS;
            ST_ABS:    n_state = ST_SHIFT;
            ST_SHIFT:  if (mg_or[48:30] == '0) n_state = ST_SQUARE;
            ST_SQUARE: if (r_cnt == 5'd3) n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_bit == 62'd1) n_state = (root_res != '0) ? ST_DIV : ST_OUT;
            end
            ST_DIV:    if (r_cnt == 5'd16 && r_div_i == 2'd2) n_state = ST_OUT;
            ST_OUT:    if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control outputs: handshake, memory port and multiplier operands.
    always_comb begin
        i_pt.ready = (r_state == ST_IDLE);
        ram_raddr  = (r_state == ST_RD_B) ? r_addr_b : r_addr_a;
        ram_we     = (r_state == ST_WIN);
        op_a       = '0;
        op_b       = '0;
        if (r_state == ST_CROSS) begin
            unique case (r_cnt)
                5'd0: begin op_a = 32'(r_u[1]); op_b = 32'(r_v[2]); end
                5'd1: begin op_a = 32'(r_u[2]); op_b = 32'(r_v[1]); end
                5'd2: begin op_a = 32'(r_u[2]); op_b = 32'(r_v[0]); end
                5'd3: begin op_a = 32'(r_u[0]); op_b = 32'(r_v[2]); end
                5'd4: begin op_a = 32'(r_u[0]); op_b = 32'(r_v[1]); end
                5'd5: begin op_a = 32'(r_u[1]); op_b = 32'(r_v[0]); end
                default: ;
            endcase
        end else if (r_state == ST_SQUARE) begin
            unique case (r_cnt)
                5'd0: begin
                    op_a = signed'({2'b00, r_mg[0][29:0]});
                    op_b = signed'({2'b00, r_mg[0][29:0]});
                end
                5'd1: begin
                    op_a = signed'({2'b00, r_mg[1][29:0]});
                    op_b = signed'({2'b00, r_mg[1][29:0]});
                end
                5'd2: begin
                    op_a = signed'({2'b00, r_mg[2][29:0]});
                    op_b = signed'({2'b00, r_mg[2][29:0]});
                end
                default: ;
            endcase
        end
    end

    assign mul = op_a * op_b;

    // One step of the bit-serial square root.
    always_comb begin
        root_t   = r_res + r_bit;
        root_ge  = (r_sum >= root_t);
        root_res = root_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    // One step of the restoring division.
    always_comb begin
        num    = {1'b0, r_mg[r_div_i][29:0], 15'd0} + {16'd0, mag[30:1]};
        rem2   = {r_rem, r_numlo[15]};
        qbit   = (rem2 >= {2'b00, mag});
        q_next = {r_q[14:0], qbit};
        res_ok = r_pts_ok && r_mag_ok && (r_qs[2] >= r_min_vert);
    end

    ocn_ram #(
        .WIDTH (72),
        .DEPTH (2 * MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr_a),
        .i_wdata (72'(r_cur)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_col_cnt <= row_last ? '0 : col_e + CW'(1);
                if (row_last && row_e < ROW_MAX) begin
                    r_row_cnt <= row_e + ROW_W'(1);
                end else begin
                    r_row_cnt <= row_e;
                end
            end
            if (r_state == ST_WIN) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[2][2] <= r_cur;
                r_win[1][2] <= rd_point;
                r_win[0][2] <= r_tmp_a;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_cur.x  <= i_pt.point_x;
                    r_cur.y  <= i_pt.point_y;
                    r_cur.z  <= i_pt.point_z;
                    r_row    <= row_e;
                    r_col    <= col_e;
                    r_addr_a <= row_e[0] ? addr_hi : addr_lo;
                    r_addr_b <= row_e[0] ? addr_lo : addr_hi;
                end
            end
            ST_RD_B: r_tmp_a <= rd_point;
            ST_DIFF: begin
                r_u[0]   <= 25'(r_win[2][2].x) - 25'(r_win[0][0].x);
                r_u[1]   <= 25'(r_win[2][2].y) - 25'(r_win[0][0].y);
                r_u[2]   <= 25'(r_win[2][2].z) - 25'(r_win[0][0].z);
                r_v[0]   <= 25'(r_win[2][0].x) - 25'(r_win[0][2].x);
                r_v[1]   <= 25'(r_win[2][0].y) - 25'(r_win[0][2].y);
                r_v[2]   <= 25'(r_win[2][0].z) - 25'(r_win[0][2].z);
                r_pts_ok <= pts_nz;
                r_mag_ok <= 1'b0;
                r_cnt    <= '0;
            end
            ST_CROSS: begin
                if (r_cnt != 5'd0) begin
                    if (!cnt_m1[0]) begin
                        r_n[cnt_m1[2:1]] <= 50'(r_prod);
                    end else begin
                        r_n[cnt_m1[2:1]] <= r_n[cnt_m1[2:1]] - 50'(r_prod);
                    end
                end
                r_cnt <= (r_cnt == 5'd6) ? 5'd0 : r_cnt + 5'd1;
            end
            ST_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    r_mg[i] <= r_n[i][49] ? 49'(-r_n[i]) : 49'(r_n[i]);
                end
                r_neg[0] <= r_n[0][49] ^ r_n[2][49];
                r_neg[1] <= r_n[1][49] ^ r_n[2][49];
            end
            ST_SHIFT: begin
                if (mg_or[48:30] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mg[i] <= r_mg[i] >> 1;
                    end
                end
                r_sum <= '0;
                r_cnt <= '0;
            end
            ST_SQUARE: begin
                if (r_cnt != 5'd0) begin
                    r_sum <= r_sum + 62'(r_prod);
                end
                r_cnt <= r_cnt + 5'd1;
                r_res <= '0;
                r_bit <= 62'd1 << 60;
            end
            ST_ROOT: begin
                if (root_ge) begin
                    r_sum <= r_sum - root_t;
                end
                r_res    <= root_res;
                r_bit    <= r_bit >> 2;
                r_mag_ok <= (root_res != '0);
                r_cnt    <= '0;
                r_div_i  <= '0;
            end
            ST_DIV: begin
                if (r_cnt == 5'd0) begin
                    r_rem   <= {2'b00, num[45:16]};
                    r_numlo <= num[15:0];
                    r_q     <= '0;
                    r_cnt   <= 5'd1;
                end else begin
                    if (qbit) begin
                        r_rem <= 32'(rem2 - {2'b00, mag});
                    end else begin
                        r_rem <= rem2[31:0];
                    end
                    r_numlo <= {r_numlo[14:0], 1'b0};
                    r_q     <= q_next;
                    if (r_cnt == 5'd16) begin
                        r_qs[r_div_i] <= q_next[15] ? 15'h7FFF : q_next[14:0];
                        r_div_i       <= r_div_i + 2'd1;
                        r_cnt         <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_nrm.ready) begin
            r_ovalid <= 1'b0;
        end
        if (out_load) begin
            r_acc  <= res_ok;
            r_nx   <= !res_ok ? 16'sd0 :
                      r_neg[0] ? -signed'({1'b0, r_qs[0]}) : signed'({1'b0, r_qs[0]});
            r_ny   <= !res_ok ? 16'sd0 :
                      r_neg[1] ? -signed'({1'b0, r_qs[1]}) : signed'({1'b0, r_qs[1]});
            r_nz   <= res_ok ? r_qs[2] : 15'd0;
            r_crow <= r_row - ROW_W'(1);
            r_ccol <= 10'(r_col - CW'(1));
        end
    end

    assign o_nrm.valid         = r_ovalid;
    assign o_nrm.normal_x      = r_nx;
    assign o_nrm.normal_y      = r_ny;
    assign o_nrm.normal_z      = r_nz;
    assign o_nrm.accepted      = r_acc;
    assign o_nrm.center_row    = r_crow;
    assign o_nrm.center_column = r_ccol;

`ifndef SYNTH
    a_acc_meets_tol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_nrm.valid && o_nrm.accepted) |-> (o_nrm.normal_z >= r_min_vert))
        else $error("accepted normal below the vertical tolerance");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_nrm.valid && !o_nrm.accepted) |->
        (o_nrm.normal_x == 16'sd0 && o_nrm.normal_y == 16'sd0 && o_nrm.normal_z == 15'd0))
        else $error("rejected normal is not zero");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> (r_state == ST_RD_A))
        else $error("accepted point did not start the line store read");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (mag != '0))
        else $error("division entered with zero magnitude");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != 5'd0) |-> ({1'b0, r_rem} < {2'b00, mag}))
        else $error("division remainder not below the divisor");
`endif
endmodule
`default_nettype wire
